@@ rtl/lsal_pkg.sv @@
// Package for the light sensor autorange block: range tables, correction
// coefficients and the command/status structs between controller and datapath.
// No dependencies.
package lsal_pkg;

	localparam int CountW = 16;
	localparam int LuxW = 40;
	localparam int XW = 26;
	localparam int OpW = 40;
	localparam int AccW = 64;

	// floor(n / 625) = (n * RECIP_625) >> 35, exact for n < 2^25
	localparam logic [25:0] RECIP_625 = 26'd54975582;
	// half of 625, rounded down; the scaled count is even so this rounds half up
	localparam logic [8:0] ROUND_ADD = 9'd312;
	// scaled count carries 2^6 on top of the gain and time shift
	localparam logic [3:0] SHIFT_BASE = 4'd6;

	localparam logic signed [OpW-1:0] COEF_A = 40'sd2839795084;
	localparam logic signed [AccW-1:0] COEF_B = 64'sd676793746;
	localparam logic signed [AccW-1:0] COEF_C = 64'sd5871829222963;
	localparam logic signed [AccW-1:0] COEF_D = 64'sd1102040504520;
	localparam logic [LuxW-1:0] LUX_MAX = 40'hFF_FFFF_FFFF;

	localparam logic [1:0] CFG_CHANNEL = 2'd0;
	localparam logic [1:0] CFG_LOW = 2'd1;
	localparam logic [1:0] CFG_HIGH = 2'd2;

	localparam logic [1:0] OUTC_TOP = 2'd0;
	localparam logic [1:0] OUTC_CORR = 2'd1;
	localparam logic [1:0] OUTC_BRIGHT = 2'd2;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_UP    = 4'b0010,
		PH_DOWN  = 4'b0100,
		PH_FINAL = 4'b1000
	} phase_t;

	typedef struct packed {
		logic start;
		logic corrected;
		logic [CountW-1:0] count;
		logic [3:0] shift;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic [LuxW-1:0] lux;
	} dp_sts_t;

	// gain step 1..4 -> sensor gain bits
	function automatic logic [1:0] gain_bits(input logic [1:0] idx);
		case (idx)
			2'd0: gain_bits = 2'd2;
			2'd1: gain_bits = 2'd3;
			2'd2: gain_bits = 2'd0;
			default: gain_bits = 2'd1;
		endcase
	endfunction

	// log2 of gain factor 16,8,2,1
	function automatic logic [2:0] gain_shift(input logic [1:0] idx);
		case (idx)
			2'd0: gain_shift = 3'd4;
			2'd1: gain_shift = 3'd3;
			2'd2: gain_shift = 3'd1;
			default: gain_shift = 3'd0;
		endcase
	endfunction

	function automatic logic [3:0] time_bits(input logic [2:0] idx);
		case (idx)
			3'd0: time_bits = 4'd12;
			3'd1: time_bits = 4'd8;
			3'd2: time_bits = 4'd0;
			3'd3: time_bits = 4'd1;
			3'd4: time_bits = 4'd2;
			default: time_bits = 4'd3;
		endcase
	endfunction

	function automatic logic [9:0] time_ms(input logic [2:0] idx);
		case (idx)
			3'd0: time_ms = 10'd25;
			3'd1: time_ms = 10'd50;
			3'd2: time_ms = 10'd100;
			3'd3: time_ms = 10'd200;
			3'd4: time_ms = 10'd400;
			default: time_ms = 10'd800;
		endcase
	endfunction

endpackage

@@ rtl/lsal_dp.sv @@
// Lux datapath: count scaling and divide by 625 through a reciprocal
// multiply in states QA, QB and QC, then a shared multiplier that steps
// through the quartic correction. Uses lsal_pkg.
module lsal_dp (
	input  logic clk,
	input  logic arst_n,
	input  lsal_pkg::dp_cmd_t cmd,
	output lsal_pkg::dp_sts_t sts
);

	typedef enum logic [5:0] {
		D_IDLE  = 6'b000001,
		D_QA    = 6'b000010,
		D_QB    = 6'b000100,
		D_QC    = 6'b001000,
		D_MUL   = 6'b010000,
		D_CLAMP = 6'b100000
	} dstate_t;

	dstate_t state_q;
	logic corr_q;
	logic [1:0] step_q;
	logic done_q;
	logic [19:0] c9_q;
	logic [3:0] j_q;
	logic [9:0] a_q;
	logic [24:0] n2_q;
	logic [lsal_pkg::XW-1:0] x_q;
	logic signed [lsal_pkg::AccW-1:0] acc_q;
	logic [lsal_pkg::LuxW-1:0] lux_q;

	logic [24:0] mul_in;
	logic [50:0] recip_prod;
	logic [15:0] quot;
	logic [19:0] a_mul;
	logic [9:0] rem_b;
	logic [lsal_pkg::XW-1:0] x_next;
	logic signed [lsal_pkg::AccW-1:0] t_sum;
	logic signed [lsal_pkg::OpW-1:0] op;
	logic signed [lsal_pkg::OpW+lsal_pkg::XW:0] prod;
	logic signed [lsal_pkg::AccW-1:0] y;

	// x = floor((count*9*2^j + 312) / 625), j = shift + 6, split as
	// count*9 = a*625 + b, x = a*2^j + floor((b*2^j + 312) / 625)
	assign mul_in = (state_q == D_QA) ? {5'd0, c9_q} : n2_q;
	assign recip_prod = {26'd0, mul_in} * {25'd0, lsal_pkg::RECIP_625};
	assign quot = recip_prod[50:35];
	assign a_mul = {10'd0, a_q} * 20'd625;
	assign rem_b = 10'(c9_q - a_mul);
	assign x_next = ({{(lsal_pkg::XW-10){1'b0}}, a_q} << j_q)
		+ {{(lsal_pkg::XW-16){1'b0}}, quot};

	always_comb begin
		t_sum = '0;
		op = lsal_pkg::COEF_A;
		case (step_q)
			2'd0: op = lsal_pkg::COEF_A;
			2'd1: begin
				t_sum = (acc_q >>> 24) - lsal_pkg::COEF_B;
				op = t_sum[lsal_pkg::OpW-1:0];
			end
			2'd2: begin
				t_sum = ((acc_q >>> 8) + lsal_pkg::COEF_C) >>> 16;
				op = t_sum[lsal_pkg::OpW-1:0];
			end
			default: begin
				t_sum = ((acc_q >>> 8) + lsal_pkg::COEF_D) >>> 16;
				op = t_sum[lsal_pkg::OpW-1:0];
			end
		endcase
	end

	assign prod = op * $signed({1'b0, x_q});
	assign y = (acc_q + 64'sd8388608) >>> 24;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			corr_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			// plain result lands with x, corrected one after the clamp
			done_q <= (state_q == D_QC && !corr_q) || (state_q == D_CLAMP);
			case (state_q)
				D_IDLE: begin
					if (cmd.start) begin
						state_q <= D_QA;
						corr_q <= cmd.corrected;
					end
				end
				D_QA: state_q <= D_QB;
				D_QB: state_q <= D_QC;
				D_QC: begin
					step_q <= '0;
					if (corr_q) begin
						state_q <= D_MUL;
					end else begin
						state_q <= D_IDLE;
					end
				end
				D_MUL: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= D_CLAMP;
					end
				end
				D_CLAMP: state_q <= D_IDLE;
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (cmd.start) begin
					c9_q <= {4'd0, cmd.count} * 20'd9;
					j_q <= cmd.shift + lsal_pkg::SHIFT_BASE;
				end
			end
			D_QA: a_q <= quot[9:0];
			D_QB: n2_q <= ({15'd0, rem_b} << j_q) + {16'd0, lsal_pkg::ROUND_ADD};
			D_QC: begin
				x_q <= x_next;
				if (!corr_q) begin
					lux_q <= {{(lsal_pkg::LuxW-lsal_pkg::XW){1'b0}}, x_next};
				end
			end
			D_MUL: acc_q <= prod[lsal_pkg::AccW-1:0];
			D_CLAMP: begin
				if (y < 0) begin
					lux_q <= '0;
				end else if (y > $signed({24'd0, lsal_pkg::LUX_MAX})) begin
					lux_q <= lsal_pkg::LUX_MAX;
				end else begin
					lux_q <= y[lsal_pkg::LuxW-1:0];
				end
			end
			default: ;
		endcase
	end

	assign sts.done = done_q;
	assign sts.lux = lux_q;

endmodule

@@ rtl/lsal_ctrl.sv @@
// Range controller: phase, gain and time steps, result fields of each beat,
// and sequencing of the lux datapath. Uses lsal_pkg.
module lsal_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic command,
	input  logic [15:0] raw_count,
	input  logic [15:0] low_limit,
	input  logic [15:0] high_limit,
	input  logic slot_free,
	input  lsal_pkg::dp_sts_t dp_sts,
	output lsal_pkg::dp_cmd_t dp_cmd,
	output logic ready,
	output logic load,
	output logic [15:0] cfg_word,
	output logic [9:0] wait_val,
	output logic done_val,
	output logic [1:0] outc_val
);

	typedef enum logic [2:0] {
		C_READY = 3'b001,
		C_CALC  = 3'b010,
		C_HOLD  = 3'b100
	} cstate_t;

	cstate_t state_q;
	lsal_pkg::phase_t phase_q, phase_d;
	logic [2:0] gain_q, gain_d;
	logic signed [2:0] time_q, time_d;
	logic [1:0] outc_q, outc_d;
	logic [15:0] cfg_q;
	logic [9:0] wait_q;
	logic done_q;
	logic [1:0] outr_q;

	logic shutdown, final_hit;
	logic [1:0] gidx;
	logic [2:0] tidx;
	logic [3:0] shift;

	always_comb begin
		phase_d = phase_q;
		gain_d = gain_q;
		time_d = time_q;
		outc_d = outc_q;
		shutdown = 1'b0;
		final_hit = 1'b0;
		if (!command) begin
			gain_d = 3'd1;
			time_d = 3'sd0;
			outc_d = lsal_pkg::OUTC_TOP;
			phase_d = lsal_pkg::PH_UP;
		end else begin
			case (phase_q)
				lsal_pkg::PH_UP: begin
					if (raw_count <= low_limit) begin
						if (gain_q <= 3'd3) gain_d = gain_q + 3'd1;
						if (gain_d >= 3'd4) begin
							if (time_q <= 3'sd2) time_d = time_q + 3'sd1;
							if (time_d >= 3'sd3) begin
								outc_d = lsal_pkg::OUTC_TOP;
								phase_d = lsal_pkg::PH_FINAL;
							end
						end
					end else begin
						phase_d = lsal_pkg::PH_DOWN;
					end
				end
				lsal_pkg::PH_DOWN: begin
					if (raw_count > high_limit) begin
						if (time_q >= -3'sd1) time_d = time_q - 3'sd1;
						if (time_d <= -3'sd2) begin
							outc_d = lsal_pkg::OUTC_BRIGHT;
							phase_d = lsal_pkg::PH_FINAL;
						end
					end else begin
						outc_d = lsal_pkg::OUTC_CORR;
						phase_d = lsal_pkg::PH_FINAL;
					end
				end
				lsal_pkg::PH_FINAL: begin
					final_hit = 1'b1;
					shutdown = 1'b1;
					phase_d = lsal_pkg::PH_IDLE;
				end
				default: shutdown = 1'b1;
			endcase
		end
	end

	assign gidx = 2'(gain_d - 3'd1);
	assign tidx = 3'(time_d + 3'sd2);
	// total shift = log2(gain factor) + 3 - time step, 0..9
	assign shift = {1'b0, lsal_pkg::gain_shift(2'(gain_q - 3'd1))} + 4'd3
		- {time_q[2], time_q};

	assign ready = (state_q == C_READY);
	assign load = (state_q == C_HOLD) && slot_free;

	assign dp_cmd.start = in_fire && final_hit;
	assign dp_cmd.corrected = (outc_q == lsal_pkg::OUTC_CORR);
	assign dp_cmd.count = raw_count;
	assign dp_cmd.shift = shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_READY;
			phase_q <= lsal_pkg::PH_IDLE;
			gain_q <= 3'd1;
			time_q <= 3'sd0;
			outc_q <= lsal_pkg::OUTC_TOP;
		end else begin
			case (state_q)
				C_READY: begin
					if (in_fire) begin
						phase_q <= phase_d;
						gain_q <= gain_d;
						time_q <= time_d;
						outc_q <= outc_d;
						state_q <= final_hit ? C_CALC : C_HOLD;
					end
				end
				C_CALC: if (dp_sts.done) state_q <= C_HOLD;
				C_HOLD: if (slot_free) state_q <= C_READY;
				default: state_q <= C_READY;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cfg_q <= {3'd0, lsal_pkg::gain_bits(gidx), 1'b0, lsal_pkg::time_bits(tidx),
				5'd0, shutdown};
			done_q <= final_hit;
			outr_q <= final_hit ? outc_q : lsal_pkg::OUTC_TOP;
			if (!shutdown) begin
				wait_q <= lsal_pkg::time_ms(tidx) + 10'd5;
			end else if (final_hit) begin
				wait_q <= 10'd3;
			end else begin
				wait_q <= 10'd0;
			end
		end
	end

	assign cfg_word = cfg_q;
	assign wait_val = wait_q;
	assign done_val = done_q;
	assign outc_val = outr_q;

endmodule

@@ rtl/light_sensor_autorange_lux.sv @@
// Top level of the light sensor autorange controller: configuration
// registers, output register, controller and lux datapath. Uses lsal_pkg.
//
// One input beat in, one result beat out. A start (command 0) or a count
// beat that only steps the range goes through the HOLD state into the
// output register once the output slot is free, and the input takes no new
// beat until then. The count beat of the final phase runs the lux datapath:
// states QA, QB and QC scale the count and divide by 625 through a
// reciprocal multiply, and when the range outcome is "corrected" the MUL
// state steps the shared multiplier through the quartic correction and the
// CLAMP state clamps the result. The controller waits in CALC for the
// datapath's done before HOLD. The input side takes the next beat as soon
// as the previous result has moved into the output register, even if that
// result is still stalled there. Configuration writes are plain register
// writes.
module light_sensor_autorange_lux (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic in_valid,
	output logic in_stall,
	input  logic command,
	input  logic [15:0] raw_count,
	output logic out_valid,
	input  logic out_stall,
	output logic [15:0] config_word,
	output logic [3:0] read_register,
	output logic [9:0] wait_ms,
	output logic done_res,
	output logic [1:0] range_outcome,
	output logic [39:0] lux_value
);

	logic chan_q;
	logic [15:0] low_q, high_q;
	logic out_valid_q;
	logic ready, load, in_fire, slot_free;
	logic [15:0] cfg_word;
	logic [9:0] wait_val;
	logic done_val;
	logic [1:0] outc_val;
	logic [3:0] rreg_q;
	lsal_pkg::dp_cmd_t dp_cmd;
	lsal_pkg::dp_sts_t dp_sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= 1'b0;
			low_q <= 16'd100;
			high_q <= 16'd10000;
		end else if (cfg_we) begin
			case (cfg_index)
				lsal_pkg::CFG_CHANNEL: chan_q <= cfg_wdata[0];
				lsal_pkg::CFG_LOW: low_q <= cfg_wdata;
				lsal_pkg::CFG_HIGH: high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign in_stall = !ready;
	assign in_fire = in_valid && ready;
	// output slot frees when empty or its beat leaves this edge
	assign slot_free = !out_valid_q || !out_stall;

	lsal_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_fire(in_fire),
		.command(command),
		.raw_count(raw_count),
		.low_limit(low_q),
		.high_limit(high_q),
		.slot_free(slot_free),
		.dp_sts(dp_sts),
		.dp_cmd(dp_cmd),
		.ready(ready),
		.load(load),
		.cfg_word(cfg_word),
		.wait_val(wait_val),
		.done_val(done_val),
		.outc_val(outc_val)
	);

	lsal_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(dp_cmd),
		.sts(dp_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rreg_q <= 4'd4 + {3'd0, chan_q};
		end
		if (load) begin
			config_word <= cfg_word;
			read_register <= rreg_q;
			wait_ms <= wait_val;
			done_res <= done_val;
			range_outcome <= outc_val;
			lux_value <= done_val ? dp_sts.lux : 40'd0;
		end
	end

	assign out_valid = out_valid_q;

endmodule
